@@ hdl/tolerant_vertex_dedup_table_defines.svh @@
// Assertion macros for the vertex dedup table checker.
// No dependencies; included by files that assert.
`ifndef TOLERANT_VERTEX_DEDUP_TABLE_DEFINES_SVH
`define TOLERANT_VERTEX_DEDUP_TABLE_DEFINES_SVH

// Same-cycle implication, sampled on aclk, off while in reset
`define TVDT_ASSERT_NOW(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, sampled on aclk, off while in reset
`define TVDT_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error(msg);

`endif

@@ hdl/tvdt_pkg.sv @@
// Shared types and constants for the vertex dedup table.
// No dependencies; imported by every module of the block.
`timescale 1ns / 1ps

package tvdt_pkg;

    localparam int TABLE_DEPTH = 1024;
    localparam int ADDR_W      = $clog2(TABLE_DEPTH);
    localparam int IDX_W       = ADDR_W + 1;
    localparam int COORD_W     = 32;
    localparam int TOL_W       = 16;
    localparam logic [TOL_W-1:0] TOL_RESET = TOL_W'(1);

    typedef struct packed {
        logic signed [COORD_W-1:0] coord_x;
        logic signed [COORD_W-1:0] coord_y;
        logic signed [COORD_W-1:0] coord_z;
        logic                      new_mesh;
    } vtx_in_t;

    typedef struct packed {
        logic [IDX_W-1:0] vertex_index;
        logic             was_found;
        logic             table_full;
    } vtx_out_t;

    typedef struct packed {
        logic start;
        logic scan;
        logic finish;
    } ctl_cmd_t;

    typedef struct packed {
        logic empty;
        logic hit;
        logic scan_done;
        logic out_free;
    } ctl_stat_t;

endpackage

@@ hdl/tolerant_vertex_dedup_table.sv @@
// Channel  | Ports                          | Payload
// input    | s_valid s_ready s_data         | vtx_in_t  (x, y, z, new_mesh)
// result   | m_valid m_ready m_data         | vtx_out_t (index, found, full)
// config   | cfg_wr_en cfg_wr_data          | match tolerance, 16 bits
//
// The scan runs from the newest stored entry down to entry 0 and stops at the first match, so the
// newest match is reported; an empty table skips the scan. The scan reads one entry a cycle from the
// single read port of the coordinate stores.
// Synchronous active-low reset empties the table and sets the tolerance to 1; no clearing pass.
// A stalled result holds in the output register; the next item is taken meanwhile and
// waits at its result cycle until that register is free.
// Depends on tvdt_pkg, tvdt_controller and tvdt_datapath.
`timescale 1ns / 1ps

module tolerant_vertex_dedup_table
    import tvdt_pkg::*;
(
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             cfg_wr_en,
    input  logic [TOL_W-1:0] cfg_wr_data,
    input  logic             s_valid,
    output logic             s_ready,
    input  vtx_in_t          s_data,
    output logic             m_valid,
    input  logic             m_ready,
    output vtx_out_t         m_data
);

    ctl_cmd_t  cmd;
    ctl_stat_t stat;

    tvdt_controller u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .stat    (stat),
        .cmd     (cmd)
    );

    tvdt_datapath u_dp (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .s_data      (s_data),
        .cmd         (cmd),
        .stat        (stat),
        .m_valid     (m_valid),
        .m_ready     (m_ready),
        .m_data      (m_data)
    );

endmodule

@@ hdl/tvdt_datapath.sv @@
// Datapath: coordinate stores, vertex count, scan address, tolerance compare, result register.
// Depends on tvdt_pkg; driven by tvdt_controller commands.
`timescale 1ns / 1ps

module tvdt_datapath
    import tvdt_pkg::*;
(
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             cfg_wr_en,
    input  logic [TOL_W-1:0] cfg_wr_data,
    input  vtx_in_t          s_data,
    input  ctl_cmd_t         cmd,
    output ctl_stat_t        stat,
    output logic             m_valid,
    input  logic             m_ready,
    output vtx_out_t         m_data
);

    logic [COORD_W-1:0] x_mem [TABLE_DEPTH];
    logic [COORD_W-1:0] y_mem [TABLE_DEPTH];
    logic [COORD_W-1:0] z_mem [TABLE_DEPTH];

    logic [TOL_W-1:0]   tol_reg;
    logic [IDX_W-1:0]   count_reg;
    logic [ADDR_W-1:0]  addr_reg;
    logic               more_reg;
    logic               rd_vld_reg;
    logic [ADDR_W-1:0]  rd_idx_reg;
    logic [COORD_W-1:0] rd_x_reg;
    logic [COORD_W-1:0] rd_y_reg;
    logic [COORD_W-1:0] rd_z_reg;
    vtx_in_t            item_reg;
    logic               hit_reg;
    logic [ADDR_W-1:0]  hit_idx_reg;
    logic               out_valid_reg;
    vtx_out_t           out_data_reg;

    logic [IDX_W-1:0]   cnt_start;
    logic               issue;
    logic               match;
    logic               room;
    logic               append;
    logic signed [COORD_W:0] tol_pos;
    logic signed [COORD_W:0] tol_neg;

    function automatic logic axis_close(input logic [COORD_W-1:0] a,
                                        input logic [COORD_W-1:0] b,
                                        input logic signed [COORD_W:0] tp,
                                        input logic signed [COORD_W:0] tn);
        logic signed [COORD_W:0] d;
        d = $signed({a[COORD_W-1], a}) - $signed({b[COORD_W-1], b});
        return (d <= tp) && (d >= tn);
    endfunction

    always_comb begin
        cnt_start = s_data.new_mesh ? '0 : count_reg;
        tol_pos   = $signed({{(COORD_W+1-TOL_W){1'b0}}, tol_reg});
        tol_neg   = -tol_pos;
        match     = axis_close(rd_x_reg, item_reg.coord_x, tol_pos, tol_neg) &&
                    axis_close(rd_y_reg, item_reg.coord_y, tol_pos, tol_neg) &&
                    axis_close(rd_z_reg, item_reg.coord_z, tol_pos, tol_neg);
        room      = count_reg < IDX_W'(TABLE_DEPTH);
        append    = cmd.finish && !hit_reg && room;

        stat.empty     = (cnt_start == '0);
        stat.hit       = cmd.scan && rd_vld_reg && match;
        stat.scan_done = cmd.scan && ((rd_vld_reg && !match && (rd_idx_reg == '0)) ||
                                      (!rd_vld_reg && !more_reg));
        stat.out_free  = !out_valid_reg || m_ready;
        issue          = cmd.scan && more_reg && !stat.hit;
    end

    // Tolerance register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            tol_reg <= TOL_RESET;
        end else if (cfg_wr_en) begin
            tol_reg <= cfg_wr_data;
        end
    end

    // Stores: one read port for the scan, one write port for the append
    always_ff @(posedge aclk) begin
        if (issue) begin
            rd_x_reg <= x_mem[addr_reg];
            rd_y_reg <= y_mem[addr_reg];
            rd_z_reg <= z_mem[addr_reg];
        end
        if (append) begin
            x_mem[count_reg[ADDR_W-1:0]] <= item_reg.coord_x;
            y_mem[count_reg[ADDR_W-1:0]] <= item_reg.coord_y;
            z_mem[count_reg[ADDR_W-1:0]] <= item_reg.coord_z;
        end
    end

    // Scan control and count
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            count_reg  <= '0;
            more_reg   <= 1'b0;
            rd_vld_reg <= 1'b0;
            hit_reg    <= 1'b0;
        end else begin
            rd_vld_reg <= issue;
            if (cmd.start) begin
                count_reg <= cnt_start;
                more_reg  <= (cnt_start != '0);
                hit_reg   <= 1'b0;
            end else begin
                if (issue && (addr_reg == '0)) begin
                    more_reg <= 1'b0;
                end
                if (stat.hit) begin
                    hit_reg <= 1'b1;
                end
                if (append) begin
                    count_reg <= count_reg + IDX_W'(1);
                end
            end
        end
    end

    // Payload registers
    always_ff @(posedge aclk) begin
        if (cmd.start) begin
            item_reg <= s_data;
            addr_reg <= ADDR_W'(cnt_start - IDX_W'(1));
        end else if (issue) begin
            addr_reg <= addr_reg - ADDR_W'(1);
        end
        if (issue) begin
            rd_idx_reg <= addr_reg;
        end
        if (stat.hit) begin
            hit_idx_reg <= rd_idx_reg;
        end
    end

    // Result register: hold until the transfer completes
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (cmd.finish) begin
            out_valid_reg <= 1'b1;
        end else if (m_ready) begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.finish) begin
            out_data_reg.was_found  <= hit_reg;
            out_data_reg.table_full <= !hit_reg && !room;
            if (hit_reg) begin
                out_data_reg.vertex_index <= {1'b0, hit_idx_reg};
            end else if (room) begin
                out_data_reg.vertex_index <= count_reg;
            end else begin
                out_data_reg.vertex_index <= IDX_W'(TABLE_DEPTH);
            end
        end
    end

    assign m_valid = out_valid_reg;
    assign m_data  = out_data_reg;

endmodule

@@ hdl/tvdt_controller.sv @@
// Controller state machine: accept, scan unless the table is empty, then deliver one result.
// Depends on tvdt_pkg; commands tvdt_datapath.
`timescale 1ns / 1ps

module tvdt_controller
    import tvdt_pkg::*;
(
    input  logic      aclk,
    input  logic      aresetn,
    input  logic      s_valid,
    output logic      s_ready,
    input  ctl_stat_t stat,
    output ctl_cmd_t  cmd
);

    localparam logic [1:0] ST_IDLE   = 2'd0;
    localparam logic [1:0] ST_SCAN   = 2'd1;
    localparam logic [1:0] ST_RESULT = 2'd2;

    logic [1:0] state_reg;
    logic [1:0] state_next;

    always_comb begin
        state_next = state_reg;
        cmd        = '0;
        s_ready    = 1'b0;
        unique case (state_reg)
            ST_IDLE: begin
                s_ready   = 1'b1;
                cmd.start = s_valid;
                if (s_valid) begin
                    state_next = stat.empty ? ST_RESULT : ST_SCAN;
                end
            end
            ST_SCAN: begin
                cmd.scan = 1'b1;
                if (stat.hit || stat.scan_done) begin
                    state_next = ST_RESULT;
                end
            end
            ST_RESULT: begin
                cmd.finish = stat.out_free;
                if (stat.out_free) begin
                    state_next = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

endmodule

@@ hdl/tvdt_checker.sv @@
// Port-level checker for the vertex dedup table, attached by bind.
// Depends on tvdt_pkg and tolerant_vertex_dedup_table_defines.svh.
`timescale 1ns / 1ps
`include "tolerant_vertex_dedup_table_defines.svh"

module tvdt_checker
    import tvdt_pkg::*;
(
    input logic             aclk,
    input logic             aresetn,
    input logic             cfg_wr_en,
    input logic [TOL_W-1:0] cfg_wr_data,
    input logic             s_valid,
    input logic             s_ready,
    input vtx_in_t          s_data,
    input logic             m_valid,
    input logic             m_ready,
    input vtx_out_t         m_data
);

    `TVDT_ASSERT_NEXT(a_out_hold, m_valid && !m_ready, m_valid && $stable(m_data), "stalled result changed")
    `TVDT_ASSERT_NEXT(a_busy_after_in, s_valid && s_ready, !s_ready, "ready stayed high after a transfer")
    `TVDT_ASSERT_NOW(a_found_not_full, m_valid, !(m_data.was_found && m_data.table_full), "found and full together")
    `TVDT_ASSERT_NOW(a_full_index, m_valid && m_data.table_full, m_data.vertex_index == IDX_W'(TABLE_DEPTH), "full result with wrong index")
    `TVDT_ASSERT_NOW(a_index_range, m_valid && !m_data.table_full, m_data.vertex_index < IDX_W'(TABLE_DEPTH), "index beyond table")

endmodule

bind tolerant_vertex_dedup_table tvdt_checker u_tvdt_checker (.*);
